[hw/rtl/door_open_timeout_monitor_defines.svh]
// ----------------------------------------------------------------------------
// door open timeout monitor assertion macros
// shared property forms for the checker, clocked on aclk and held off in reset
// ----------------------------------------------------------------------------
`ifndef DOOR_OPEN_TIMEOUT_MONITOR_DEFINES_SVH
`define DOOR_OPEN_TIMEOUT_MONITOR_DEFINES_SVH

// same-cycle implication
`define DOTM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DOTM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/dotm_pkg.sv]
// ----------------------------------------------------------------------------
// dotm_pkg
// types and constants shared by the door open timeout monitor modules
// ----------------------------------------------------------------------------
package dotm_pkg;

    localparam int DOORS      = 7;
    localparam int TIME_W     = 32;
    localparam int NODE_W     = 8;
    localparam int MODE_W     = 3;
    localparam int IDX_W      = 3;
    localparam int VAL_W      = 8;
    localparam int DOOR_CNT_W = $clog2(DOORS + 1);

    // transaction modes
    localparam logic [MODE_W-1:0] MODE_SAMPLE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SET_TOL    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SET_COUNT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SET_ACTIVE = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [NODE_W-1:0] target_node;
        logic [IDX_W-1:0]  door_index;
        logic [VAL_W-1:0]  cmd_value;
        logic [DOORS-1:0]  door_sensors;
        logic [TIME_W-1:0] time_now;
    } in_item_t;

    typedef struct packed {
        logic [DOORS-1:0] new_alarms;
        logic [DOORS-1:0] alarmed_doors;
        logic             any_alarm;
        logic             red_lamp_on;
        logic [DOORS-1:0] green_lamps_on;
    } out_item_t;

    // what one door lane found during a sample pass (at most one is set)
    typedef struct packed {
        logic red_off;
        logic raise;
        logic red_on;
    } lane_ev_t;

    // combined outcome of all lanes in door order
    typedef struct packed {
        logic [DOORS-1:0] raised;
        logic             global_alarm;
        logic             red_lamp;
    } merge_res_t;

endpackage

[hw/rtl/dotm_lane.sv]
// ----------------------------------------------------------------------------
// dotm_lane
// one door: elapsed open time against its threshold, registered event out
// ----------------------------------------------------------------------------
module dotm_lane #(
    parameter int THR_W = 28
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        lane_en,
    input  logic                        lane_valid,
    input  logic                        open_flag,
    input  logic                        alarm_flag,
    input  logic                        sensor,
    input  logic [dotm_pkg::TIME_W-1:0] time_now,
    input  logic [dotm_pkg::TIME_W-1:0] open_start,
    input  logic [THR_W-1:0]            threshold,
    output dotm_pkg::lane_ev_t          ev
);

    localparam int CMP_W = (THR_W > dotm_pkg::TIME_W) ? THR_W : dotm_pkg::TIME_W;

    logic [dotm_pkg::TIME_W-1:0] elapsed;
    logic                        open_eff;
    logic                        exceed;
    dotm_pkg::lane_ev_t          ev_next;
    dotm_pkg::lane_ev_t          ev_reg;

    // elapsed time wraps with the time base
    assign elapsed  = time_now - open_start;
    assign open_eff = open_flag & sensor;
    assign exceed   = open_eff &&
                      (CMP_W'(elapsed) > CMP_W'(threshold));

    // closing comes first, then either a raise or a fresh open
    always_comb begin
        ev_next.red_off = lane_valid & ~sensor;
        ev_next.raise   = lane_valid & exceed & ~alarm_flag;
        ev_next.red_on  = lane_valid & ~exceed & ~alarm_flag & sensor & ~open_eff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev_reg <= '0;
        end else if (lane_en) begin
            ev_reg <= ev_next;
        end
    end

    assign ev = ev_reg;

endmodule

[hw/rtl/dotm_merge.sv]
// ----------------------------------------------------------------------------
// dotm_merge
// folds the lane events in door order into global alarm and red lamp
// ----------------------------------------------------------------------------
module dotm_merge (
    input  dotm_pkg::lane_ev_t [dotm_pkg::DOORS-1:0] ev,
    input  logic                                     global_alarm,
    input  logic                                     red_lamp,
    output dotm_pkg::merge_res_t                     res
);

    // lower doors act first; a raise blocks later lamp-off events
    always_comb begin
        logic g;
        logic r;
        g = global_alarm;
        r = red_lamp;
        res.raised = '0;
        for (int i = 0; i < dotm_pkg::DOORS; i++) begin
            if (ev[i].red_off && !g) begin
                r = 1'b0;
            end
            if (ev[i].raise) begin
                g = 1'b1;
                res.raised[i] = 1'b1;
            end
            if (ev[i].red_on) begin
                r = 1'b1;
            end
        end
        res.global_alarm = g;
        res.red_lamp     = r;
    end

endmodule

[hw/rtl/door_open_timeout_monitor.sv]
// ----------------------------------------------------------------------------
// door_open_timeout_monitor
// steps: input register, lane compare, then merge and state update
// one transaction at a time: a new input is taken only once the last one is
//   through merge; a result not yet taken stalls the next merge step
// reset: synchronous active low, all door state, thresholds and node id clear
// ----------------------------------------------------------------------------
module door_open_timeout_monitor #(
    parameter int TICKS_PER_SECOND = 1000000
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  dotm_pkg::in_item_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output dotm_pkg::out_item_t         m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [dotm_pkg::NODE_W-1:0] cfg_data
);

    localparam int DOORS = dotm_pkg::DOORS;
    localparam int CNT_W = dotm_pkg::DOOR_CNT_W;
    localparam int THR_W = dotm_pkg::VAL_W + $clog2(TICKS_PER_SECOND + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LANE  = 2'd1;
    localparam logic [1:0] ST_MERGE = 2'd2;

    logic [1:0]                  state_reg, state_next;
    dotm_pkg::in_item_t          in_reg;
    dotm_pkg::out_item_t         out_reg, out_next;
    logic                        m_valid_reg, m_valid_next;
    logic [dotm_pkg::NODE_W-1:0] own_node_reg;

    logic [DOORS-1:0]            active_reg, active_next;
    logic [DOORS-1:0]            open_reg, open_next;
    logic [DOORS-1:0]            alarm_reg, alarm_next;
    logic [DOORS-1:0]            green_reg, green_next;
    logic                        global_reg, global_next;
    logic                        red_reg, red_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [dotm_pkg::TIME_W-1:0] start_reg [DOORS];
    logic [dotm_pkg::TIME_W-1:0] start_next [DOORS];
    logic [THR_W-1:0]            thr_reg [DOORS];
    logic [THR_W-1:0]            thr_next [DOORS];

    logic [DOORS-1:0]                        use_mask;
    logic [DOORS-1:0]                        raised;
    logic [CNT_W-1:0]                        cnt_new;
    logic [THR_W-1:0]                        thr_product;
    logic                                    idx_ok;
    logic                                    cmd_hit;
    dotm_pkg::lane_ev_t [DOORS-1:0]          ev;
    dotm_pkg::merge_res_t                    mres;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    // doors below the configured count
    always_comb begin
        for (int i = 0; i < DOORS; i++) begin
            use_mask[i] = (CNT_W'(i) < cnt_reg);
        end
    end

    // one lane per door
    for (genvar g = 0; g < DOORS; g++) begin : g_lane
        dotm_lane #(
            .THR_W (THR_W)
        ) u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .lane_en    (state_reg == ST_LANE),
            .lane_valid (use_mask[g] & active_reg[g]),
            .open_flag  (open_reg[g]),
            .alarm_flag (alarm_reg[g]),
            .sensor     (in_reg.door_sensors[g]),
            .time_now   (in_reg.time_now),
            .open_start (start_reg[g]),
            .threshold  (thr_reg[g]),
            .ev         (ev[g])
        );
    end

    dotm_merge u_merge (
        .ev           (ev),
        .global_alarm (global_reg),
        .red_lamp     (red_reg),
        .res          (mres)
    );

    // command helpers
    assign idx_ok      = (32'(in_reg.door_index) < 32'(DOORS));
    assign cmd_hit     = (in_reg.target_node == own_node_reg);
    assign thr_product = THR_W'(in_reg.cmd_value) * THR_W'(TICKS_PER_SECOND);
    assign cnt_new     = (32'(in_reg.cmd_value) > 32'(DOORS)) ? CNT_W'(DOORS)
                                                              : in_reg.cmd_value[CNT_W-1:0];

    // sequencer and state update
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        active_next  = active_reg;
        open_next    = open_reg;
        alarm_next   = alarm_reg;
        green_next   = green_reg;
        global_next  = global_reg;
        red_next     = red_reg;
        cnt_next     = cnt_reg;
        start_next   = start_reg;
        thr_next     = thr_reg;
        raised       = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LANE;
                end
            end
            ST_LANE: begin
                state_next = ST_MERGE;
            end
            ST_MERGE: begin
                if (!m_valid_reg || m_ready) begin
                    if (in_reg.mode == dotm_pkg::MODE_SAMPLE) begin
                        for (int i = 0; i < DOORS; i++) begin
                            if (ev[i].red_off) begin
                                open_next[i] = 1'b0;
                            end
                            if (ev[i].raise) begin
                                alarm_next[i] = 1'b1;
                            end
                            if (ev[i].red_on) begin
                                open_next[i]  = 1'b1;
                                start_next[i] = in_reg.time_now;
                            end
                        end
                        global_next = mres.global_alarm;
                        red_next    = mres.red_lamp;
                        raised      = mres.raised;
                    end else if (cmd_hit) begin
                        case (in_reg.mode)
                            dotm_pkg::MODE_CLEAR: begin
                                red_next    = 1'b0;
                                global_next = 1'b0;
                                alarm_next  = alarm_reg & ~use_mask;
                                open_next   = open_reg & ~use_mask;
                            end
                            dotm_pkg::MODE_SET_TOL: begin
                                if (idx_ok) begin
                                    thr_next[in_reg.door_index] = thr_product;
                                end
                            end
                            dotm_pkg::MODE_SET_COUNT: begin
                                cnt_next = cnt_new;
                                for (int i = 0; i < DOORS; i++) begin
                                    if (CNT_W'(i) < cnt_new) begin
                                        active_next[i] = 1'b1;
                                    end
                                end
                            end
                            dotm_pkg::MODE_SET_ACTIVE: begin
                                if (idx_ok) begin
                                    active_next[in_reg.door_index] = (in_reg.cmd_value != '0);
                                    green_next[in_reg.door_index]  = (in_reg.cmd_value == '0);
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    out_next.new_alarms     = raised;
                    out_next.alarmed_doors  = alarm_next;
                    out_next.any_alarm      = global_next;
                    out_next.red_lamp_on    = red_next;
                    out_next.green_lamps_on = green_next;
                    m_valid_next            = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and door state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            own_node_reg <= '0;
            active_reg   <= '0;
            open_reg     <= '0;
            alarm_reg    <= '0;
            green_reg    <= '0;
            global_reg   <= 1'b0;
            red_reg      <= 1'b0;
            cnt_reg      <= '0;
            for (int i = 0; i < DOORS; i++) begin
                start_reg[i] <= '0;
                thr_reg[i]   <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                own_node_reg <= cfg_data;
            end
            active_reg  <= active_next;
            open_reg    <= open_next;
            alarm_reg   <= alarm_next;
            green_reg   <= green_next;
            global_reg  <= global_next;
            red_reg     <= red_next;
            cnt_reg     <= cnt_next;
            start_reg   <= start_next;
            thr_reg     <= thr_next;
        end
    end

    // input transaction and result payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        out_reg <= out_next;
    end

endmodule

[hw/rtl/dotm_checker.sv]
// ----------------------------------------------------------------------------
// dotm_checker
// port-level checks on the door open timeout monitor, bound to the top level
// ----------------------------------------------------------------------------
`include "door_open_timeout_monitor_defines.svh"

module dotm_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input dotm_pkg::out_item_t m_data
);

    // a stalled result holds
    `DOTM_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // a newly raised alarm is also in the alarm flags
    `DOTM_ASSERT_IMP(a_new_in_flags, m_valid, (m_data.new_alarms & ~m_data.alarmed_doors) == '0, "new alarm missing from alarm flags")

    // a newly raised alarm sets the global alarm
    `DOTM_ASSERT_IMP(a_new_sets_global, m_valid && (m_data.new_alarms != '0), m_data.any_alarm, "new alarm without global alarm")

    // one transaction is worked on at a time
    `DOTM_ASSERT_NXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "input accepted while busy")

endmodule

bind door_open_timeout_monitor dotm_checker u_dotm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
